### design/rhp_pkg.sv
// Shared widths and constants for the RGB to HSV pixel converter.
package rhp_pkg;

  // Channel and result widths
  localparam int unsigned CH_W  = 8;
  localparam int unsigned HUE_W = 9;
  localparam int unsigned SAT_W = 6;

  // Dividend widths: hue numerator up to 360*255, saturation numerator up to 60*255
  localparam int unsigned HNUM_W = 17;
  localparam int unsigned SNUM_W = 14;

  // Angle constants in degrees
  localparam int unsigned DEG_SECTOR = 60;
  localparam int unsigned DEG_GREEN  = 2 * 60;
  localparam int unsigned DEG_BLUE   = 4 * 60;
  localparam int unsigned DEG_FULL   = 6 * 60;

  typedef logic [CH_W-1:0]  chan_t;
  typedef logic [HUE_W-1:0] hue_t;
  typedef logic [SAT_W-1:0] sat_t;

endpackage

### design/rhp_rgb_if.sv
// Valid/ready channel that carries one RGB pixel.
interface rhp_rgb_if import rhp_pkg::*; ();
  logic  valid;
  logic  ready;
  chan_t red;
  chan_t green;
  chan_t blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

### design/rhp_hsv_if.sv
// Valid/ready channel that carries one HSV result.
interface rhp_hsv_if import rhp_pkg::*; ();
  logic  valid;
  logic  ready;
  hue_t  hue;
  sat_t  saturation;
  chan_t value;

  modport source (output valid, hue, saturation, value, input ready);
  modport sink   (input valid, hue, saturation, value, output ready);
endinterface

### design/rgb_to_hsv_pixel.sv
// RGB to HSV pixel converter: max/min stage, numerator stages, restoring divider, output.
//
// Converts one 8-bit RGB pixel per clock into hue (0..359 degrees), saturation
// (0..60, 60 meaning full) and value (largest channel). Throughput is one pixel
// every cycle while out_px.ready stays high. The item passes thirteen registers,
// the first loaded at the accepting edge: the two front stages (max/min, then
// span and scaled difference), the numerator stage at the divider entry, the
// nine stages of the restoring divider that produce one hue quotient bit each
// (the six saturation quotient bits are formed alongside in the last six), and
// the output register. Every stage holds its own valid bit and moves up whenever
// the stage after it is empty or moving, so bubbles close up under a stall and
// the input keeps accepting while a finished result waits. Grey pixels (max equal
// to min, black included) give hue and saturation of zero.
module rgb_to_hsv_pixel
  import rhp_pkg::*;
(
  input logic          clk,
  input logic          rst_n,
  rhp_rgb_if.sink      in_px,
  rhp_hsv_if.source    out_px
);

  localparam int unsigned DIV_STAGES = HUE_W;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_WRAP,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  typedef struct packed {
    logic              grey;
    chan_t             hi;
    chan_t             span;
    logic [HNUM_W-1:0] hrem;
    hue_t              hq;
    logic [SNUM_W-1:0] srem;
    sat_t              sq;
  } div_t;

  // Stage 1: max, min, sector, signed difference
  logic               s1_v_r;
  logic               s1_rdy;
  chan_t              s1_hi_r, s1_lo_r;
  sector_t            s1_sec_r;
  logic signed [8:0]  s1_sd_r;
  chan_t              s1_hi_nxt, s1_lo_nxt;
  sector_t            s1_sec_nxt;
  logic signed [8:0]  s1_sd_nxt;

  // Stage 2: span and scaled difference
  logic               s2_v_r;
  logic               s2_rdy;
  chan_t              s2_hi_r, s2_span_r;
  sector_t            s2_sec_r;
  logic signed [14:0] s2_sd60_r;
  chan_t              s2_span_nxt;
  logic signed [14:0] s2_sd60_nxt;

  // Divider stages
  logic               dv_r  [DIV_STAGES+1];
  logic               d_rdy [DIV_STAGES+1];
  div_t               d_r   [DIV_STAGES+1];
  div_t               d_nxt [DIV_STAGES+1];

  // Output register
  logic               out_v_r;
  logic               o_rdy;
  hue_t               hue_r;
  sat_t               sat_r;
  chan_t              val_r;
  hue_t               hue_nxt;

  logic [HNUM_W-1:0]  offs;
  logic signed [17:0] numw;

  // Ready chain: a stage moves when it is empty or the next one moves
  assign o_rdy  = !out_v_r || out_px.ready;
  assign s1_rdy = !s1_v_r || s2_rdy;
  assign s2_rdy = !s2_v_r || d_rdy[0];
  assign in_px.ready = s1_rdy;

  // Find max, min and sector; red wins ties over green, green over blue
  always_comb begin
    chan_t m;
    m = (in_px.red > in_px.green) ? in_px.red : in_px.green;
    s1_hi_nxt = (in_px.blue > m) ? in_px.blue : m;
    m = (in_px.red < in_px.green) ? in_px.red : in_px.green;
    s1_lo_nxt = (in_px.blue < m) ? in_px.blue : m;
    if (s1_hi_nxt == in_px.red) begin
      s1_sec_nxt = (in_px.green >= in_px.blue) ? SEC_RED : SEC_WRAP;
      s1_sd_nxt  = $signed({1'b0, in_px.green}) - $signed({1'b0, in_px.blue});
    end else if (s1_hi_nxt == in_px.green) begin
      s1_sec_nxt = SEC_GREEN;
      s1_sd_nxt  = $signed({1'b0, in_px.blue}) - $signed({1'b0, in_px.red});
    end else begin
      s1_sec_nxt = SEC_BLUE;
      s1_sd_nxt  = $signed({1'b0, in_px.red}) - $signed({1'b0, in_px.green});
    end
  end

  // Span and sixty times the signed difference
  assign s2_span_nxt = s1_hi_r - s1_lo_r;
  assign s2_sd60_nxt = 15'(s1_sd_r) * 15'sd60;

  // Hue numerator: sector offset times span plus scaled difference
  always_comb begin
    case (s2_sec_r)
      SEC_RED:   offs = '0;
      SEC_WRAP:  offs = HNUM_W'(s2_span_r) * HNUM_W'(DEG_FULL);
      SEC_GREEN: offs = HNUM_W'(s2_span_r) * HNUM_W'(DEG_GREEN);
      SEC_BLUE:  offs = HNUM_W'(s2_span_r) * HNUM_W'(DEG_BLUE);
      default:   offs = '0;
    endcase
    numw = $signed({1'b0, offs}) + 18'(s2_sd60_r);
    d_nxt[0].grey = (s2_span_r == '0);
    d_nxt[0].hi   = s2_hi_r;
    d_nxt[0].span = s2_span_r;
    d_nxt[0].hrem = numw[HNUM_W-1:0];
    d_nxt[0].hq   = '0;
    d_nxt[0].srem = SNUM_W'(s2_span_r) * SNUM_W'(DEG_SECTOR);
    d_nxt[0].sq   = '0;
  end

  // Front stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_r <= in_px.valid;
      if (s2_rdy) s2_v_r <= s1_v_r;
    end
    if (s1_rdy && in_px.valid) begin
      s1_hi_r  <= s1_hi_nxt;
      s1_lo_r  <= s1_lo_nxt;
      s1_sec_r <= s1_sec_nxt;
      s1_sd_r  <= s1_sd_nxt;
    end
    if (s2_rdy && s1_v_r) begin
      s2_hi_r   <= s1_hi_r;
      s2_span_r <= s2_span_nxt;
      s2_sec_r  <= s1_sec_r;
      s2_sd60_r <= s2_sd60_nxt;
    end
  end

  // Divider entry stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (d_rdy[0]) begin
      dv_r[0] <= s2_v_r;
    end
    if (d_rdy[0] && s2_v_r) begin
      d_r[0] <= d_nxt[0];
    end
  end

  // Restoring divider: one hue quotient bit per stage, saturation in the last six
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    localparam int unsigned HB = HUE_W - 1 - k;

    if (k == DIV_STAGES - 1) begin : g_last
      assign d_rdy[k] = !dv_r[k] || d_rdy[k+1];
    end else begin : g_mid
      assign d_rdy[k] = !dv_r[k] || d_rdy[k+1];
    end

    always_comb begin
      logic [HNUM_W-1:0] hsub;
      logic [SNUM_W-1:0] ssub;
      d_nxt[k+1] = d_r[k];
      hsub = HNUM_W'(d_r[k].span) << HB;
      ssub = '0;
      if (d_r[k].hrem >= hsub) begin
        d_nxt[k+1].hrem   = d_r[k].hrem - hsub;
        d_nxt[k+1].hq[HB] = 1'b1;
      end
      if (HB < SAT_W) begin
        ssub = SNUM_W'(d_r[k].hi) << HB;
        if (d_r[k].srem >= ssub) begin
          d_nxt[k+1].srem = d_r[k].srem - ssub;
          d_nxt[k+1].sq[HB % SAT_W] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k+1] <= 1'b0;
      end else if (d_rdy[k+1]) begin
        dv_r[k+1] <= dv_r[k];
      end
      if (d_rdy[k+1] && dv_r[k]) begin
        d_r[k+1] <= d_nxt[k+1];
      end
    end
  end

  assign d_rdy[DIV_STAGES] = !dv_r[DIV_STAGES] || o_rdy;

  // Wrap a full turn back to zero
  assign hue_nxt = (d_r[DIV_STAGES].hq >= HUE_W'(DEG_FULL))
                 ? d_r[DIV_STAGES].hq - HUE_W'(DEG_FULL)
                 : d_r[DIV_STAGES].hq;

  // Output register; force hue and saturation to zero for grey
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (o_rdy) begin
      out_v_r <= dv_r[DIV_STAGES];
    end
    if (o_rdy && dv_r[DIV_STAGES]) begin
      hue_r <= d_r[DIV_STAGES].grey ? '0 : hue_nxt;
      sat_r <= d_r[DIV_STAGES].grey ? '0 : d_r[DIV_STAGES].sq;
      val_r <= d_r[DIV_STAGES].hi;
    end
  end

  assign out_px.valid      = out_v_r;
  assign out_px.hue        = hue_r;
  assign out_px.saturation = sat_r;
  assign out_px.value      = val_r;

endmodule

### bench/tb_rgb_to_hsv_pixel.sv
`timescale 1ns / 100ps
// Testbench for the RGB to HSV pixel converter: queued pixel driver, result monitor, scoreboard.
module tb_rgb_to_hsv_pixel
  import rhp_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RAND_PIXELS = 1400;
  localparam int unsigned HOLD_AFTER  = 300;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned MAX_REPORTS = 10;

  typedef enum logic [1:0] {
    PH_RX_SLOW,
    PH_TX_SLOW,
    PH_FULL_RATE
  } idle_phase_t;

  typedef struct packed {
    chan_t       red;
    chan_t       green;
    chan_t       blue;
    idle_phase_t phase;
    logic        drain;
  } pixel_item_t;

  typedef struct packed {
    hue_t  hue;
    sat_t  saturation;
    chan_t value;
  } hsv_t;

  logic clk;
  logic rst_n;

  rhp_rgb_if in_if ();
  rhp_hsv_if out_if ();

  rgb_to_hsv_pixel dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_px  (in_if),
    .out_px (out_if)
  );

  pixel_item_t pixel_queue[$];
  hsv_t        hsv_expect[$];
  idle_phase_t cur_phase;
  int unsigned accepted_cnt;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned hold_left;
  logic        hold_done;

  // Integer HSV conversion: value is the max, saturation on a 0..60 scale
  function automatic hsv_t predict_hsv(chan_t r, chan_t g, chan_t b);
    int unsigned rc, gc, bc, hi, lo, span, num, hue;
    hsv_t res;
    rc = 32'(r);
    gc = 32'(g);
    bc = 32'(b);
    hi = rc;
    if (gc > hi) hi = gc;
    if (bc > hi) hi = bc;
    lo = rc;
    if (gc < lo) lo = gc;
    if (bc < lo) lo = bc;
    span = hi - lo;
    hue = 0;
    res.saturation = '0;
    if (span != 0) begin
      res.saturation = sat_t'((span * DEG_SECTOR) / hi);
      // red wins ties over green, green over blue
      if (hi == rc) begin
        if (gc >= bc) begin
          num = (gc - bc) * DEG_SECTOR;
        end else begin
          num = DEG_FULL * span - (bc - gc) * DEG_SECTOR;
        end
      end else if (hi == gc) begin
        num = DEG_GREEN * span + bc * DEG_SECTOR - rc * DEG_SECTOR;
      end else begin
        num = DEG_BLUE * span + rc * DEG_SECTOR - gc * DEG_SECTOR;
      end
      hue = num / span;
      if (hue >= DEG_FULL) hue = hue - DEG_FULL;
    end
    res.hue   = hue_t'(hue);
    res.value = chan_t'(hi);
    return res;
  endfunction

  function automatic int unsigned tx_idle_pct(idle_phase_t ph);
    case (ph)
      PH_RX_SLOW: return 7;
      PH_TX_SLOW: return 54;
      default:    return 0;
    endcase
  endfunction

  function automatic int unsigned rx_idle_pct(idle_phase_t ph);
    case (ph)
      PH_RX_SLOW: return 54;
      PH_TX_SLOW: return 7;
      default:    return 0;
    endcase
  endfunction

  task automatic add_pixel(chan_t r, chan_t g, chan_t b, idle_phase_t ph, logic drain);
    pixel_item_t it;
    it.red   = r;
    it.green = g;
    it.blue  = b;
    it.phase = ph;
    it.drain = drain;
    pixel_queue.push_back(it);
  endtask

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Fill the pixel queue, then wait for the pipeline to drain and report
  initial begin
    chan_t       r, g, b, v;
    idle_phase_t ph;
    int unsigned pick;
    // greys, pure primaries, ties for the max, hue near the wrap, tiny spans
    add_pixel(8'd0,   8'd0,   8'd0,   PH_RX_SLOW, 1'b0);
    add_pixel(8'd255, 8'd255, 8'd255, PH_RX_SLOW, 1'b0);
    add_pixel(8'd128, 8'd128, 8'd128, PH_RX_SLOW, 1'b0);
    add_pixel(8'd255, 8'd0,   8'd0,   PH_RX_SLOW, 1'b0);
    add_pixel(8'd0,   8'd255, 8'd0,   PH_RX_SLOW, 1'b0);
    add_pixel(8'd0,   8'd0,   8'd255, PH_RX_SLOW, 1'b0);
    add_pixel(8'd255, 8'd255, 8'd0,   PH_RX_SLOW, 1'b0);
    add_pixel(8'd0,   8'd255, 8'd255, PH_RX_SLOW, 1'b0);
    add_pixel(8'd255, 8'd0,   8'd255, PH_RX_SLOW, 1'b0);
    add_pixel(8'd255, 8'd0,   8'd1,   PH_RX_SLOW, 1'b0);
    add_pixel(8'd255, 8'd1,   8'd0,   PH_RX_SLOW, 1'b0);
    add_pixel(8'd1,   8'd0,   8'd0,   PH_RX_SLOW, 1'b0);
    add_pixel(8'd255, 8'd254, 8'd254, PH_RX_SLOW, 1'b0);
    add_pixel(8'd1,   8'd1,   8'd0,   PH_RX_SLOW, 1'b0);
    add_pixel(8'd0,   8'd1,   8'd1,   PH_RX_SLOW, 1'b0);
    add_pixel(8'd1,   8'd0,   8'd1,   PH_RX_SLOW, 1'b0);
    add_pixel(8'd200, 8'd50,  8'd100, PH_RX_SLOW, 1'b0);
    add_pixel(8'd50,  8'd200, 8'd100, PH_RX_SLOW, 1'b0);
    add_pixel(8'd100, 8'd50,  8'd200, PH_RX_SLOW, 1'b0);
    add_pixel(8'd255, 8'd128, 8'd0,   PH_RX_SLOW, 1'b0);
    add_pixel(8'd254, 8'd255, 8'd253, PH_RX_SLOW, 1'b0);
    add_pixel(8'd128, 8'd127, 8'd0,   PH_RX_SLOW, 1'b0);
    add_pixel(8'd0,   8'd128, 8'd255, PH_RX_SLOW, 1'b0);

    // random pixels with a bias toward greys, ties and narrow spans
    for (int i = 0; i < RAND_PIXELS; i++) begin
      if (i < RAND_PIXELS / 3) ph = PH_RX_SLOW;
      else if (i < 2 * RAND_PIXELS / 3) ph = PH_TX_SLOW;
      else ph = PH_FULL_RATE;
      pick = $urandom_range(0, 2);
      case ($urandom_range(0, 9))
        0: begin
          v = chan_t'($urandom_range(0, 255));
          r = v;
          g = v;
          b = v;
        end
        1: begin
          v = chan_t'($urandom_range(0, 255));
          r = v;
          g = v;
          b = v;
          case (pick)
            0: r = chan_t'($urandom_range(0, v));
            1: g = chan_t'($urandom_range(0, v));
            default: b = chan_t'($urandom_range(0, v));
          endcase
        end
        2: begin
          v = chan_t'($urandom_range(2, 255));
          r = v;
          g = v - chan_t'($urandom_range(0, 1));
          b = v - chan_t'($urandom_range(0, 2));
          if (pick == 1) begin
            v = r;
            r = g;
            g = v;
          end else if (pick == 2) begin
            v = r;
            r = b;
            b = v;
          end
        end
        default: begin
          r = chan_t'($urandom_range(0, 255));
          g = chan_t'($urandom_range(0, 255));
          b = chan_t'($urandom_range(0, 255));
        end
      endcase
      add_pixel(r, g, b, ph, (i == 0 || i == RAND_PIXELS / 3 || i == RAND_PIXELS / 2 ||
                              i == 2 * RAND_PIXELS / 3));
    end

    @(posedge clk);
    while (!rst_n) @(posedge clk);
    do @(posedge clk);
    while (pixel_queue.size() != 0 || in_if.valid || hsv_expect.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (err_cnt == 0 && hsv_expect.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Driver: hold the offered item until taken, then pick the next one or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid  <= 1'b0;
      in_if.red    <= '0;
      in_if.green  <= '0;
      in_if.blue   <= '0;
      accepted_cnt <= 0;
      cur_phase    <= PH_RX_SLOW;
    end else begin
      if (in_if.valid && in_if.ready) begin
        hsv_expect.push_back(predict_hsv(in_if.red, in_if.green, in_if.blue));
        cur_phase <= pixel_queue[0].phase;
        void'(pixel_queue.pop_front());
        accepted_cnt <= accepted_cnt + 1;
      end
      if (in_if.valid && !in_if.ready) begin
        // hold: item still on offer
      end else if (pixel_queue.size() == 0) begin
        in_if.valid <= 1'b0;
      end else if (pixel_queue[0].drain && hsv_expect.size() != 0) begin
        in_if.valid <= 1'b0;
      end else if ($urandom_range(0, 99) < tx_idle_pct(pixel_queue[0].phase)) begin
        in_if.valid <= 1'b0;
      end else begin
        in_if.valid <= 1'b1;
        in_if.red   <= pixel_queue[0].red;
        in_if.green <= pixel_queue[0].green;
        in_if.blue  <= pixel_queue[0].blue;
      end
    end
  end

  // Receiver: one long hold-off to back up the pipeline, random stalls otherwise
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else if (!hold_done && accepted_cnt >= HOLD_AFTER) begin
      hold_done    <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct(cur_phase));
    end
  end

  // Monitor: compare each result against the oldest prediction
  always @(posedge clk) begin
    hsv_t exp_px;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (hsv_expect.size() == 0) begin
        err_cnt <= err_cnt + 1;
        if (err_cnt < MAX_REPORTS)
          $display("unexpected result: hue %0d sat %0d value %0d",
                   out_if.hue, out_if.saturation, out_if.value);
      end else begin
        exp_px = hsv_expect.pop_front();
        if (out_if.hue !== exp_px.hue || out_if.saturation !== exp_px.saturation ||
            out_if.value !== exp_px.value) begin
          err_cnt <= err_cnt + 1;
          if (err_cnt < MAX_REPORTS)
            $display("mismatch: expected hue %0d sat %0d value %0d, got hue %0d sat %0d value %0d",
                     exp_px.hue, exp_px.saturation, exp_px.value,
                     out_if.hue, out_if.saturation, out_if.value);
        end
      end
    end
  end

  // Watchdog: end the run if it stalls
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule
